// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file; empty bodies under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, disabled while reset is asserted.
`define TKH_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define TKH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define TKH_ASSERT(lbl, clk, rstn, prop, msg)
`define TKH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== design/tkh_pkg.sv =====
// Shared constants, opcodes and sequencer states of the top-k heap selector.
package tkh_pkg;

	// Default sizing of the heap store
	localparam int DEF_CAPACITY   = 1024;
	localparam int DEF_VALUE_BITS = 30;

	// Fixed widths of the keep limit register and the kept count output
	localparam int KEEP_W = 11;
	localparam int KEPT_W = 11;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 11'd1024;

	// Item opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_R_CHK,
		S_R_CMP,
		S_EV_CHK,
		S_F_RD,
		S_F_CMP,
		S_P_RD,
		S_P_OUT,
		S_EV_LD,
		S_SK_A,
		S_SK_B,
		S_SK_C,
		S_SK_D
	} state_t;

endpackage

// ===== design/top_k_smallest_heap.sv =====
// Top level of the top-k smallest selector: heap sequencer and store.
//
// Keeps the keep_count smallest pushed values in a binary max-heap held in one
// RAM with a single read and a single write port, so the largest kept value is
// at the root. An item is taken when start is high and busy is low; busy then
// stays high until the heap is settled, but a pop on an empty heap leaves it
// low. A push writes the value at the end and raises it toward the root; when
// the store then holds more than the keep limit, the root is evicted and the
// last entry moves to the root and sinks. A push into a full store compares
// the value with the root and, only when the value is below it, replaces the
// root and sinks. A pop reads the root, then moves the last entry to the root
// and sinks it. Each rising step costs one RAM read and one compare in the
// shared comparator; a sinking step reads the children and uses it twice.
// With 1024 entries a value rises or sinks at most 10 levels. A pop reports
// its result on popped_value, was_empty and kept_after for exactly one cycle
// with done high; the receiver cannot stall it, so it must take the item in
// that cycle. keep_count is written on the cfg channel, accepted while the
// block is idle.
module top_k_smallest_heap #(
	parameter int CAPACITY   = tkh_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = tkh_pkg::DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [VALUE_BITS-1:0]       sample_value,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tkh_pkg::KEEP_W-1:0]  cfg_data,
	output logic                        done,
	output logic [VALUE_BITS-1:0]       popped_value,
	output logic                        was_empty,
	output logic [tkh_pkg::KEPT_W-1:0]  kept_after
);

	`include "assert_macros.svh"

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int EW   = AW + 2;
	localparam int LIMW = CW + tkh_pkg::KEEP_W;
	localparam int KXW  = CW + tkh_pkg::KEPT_W;

	tkh_pkg::state_t state_q, state_d;

	logic [VALUE_BITS-1:0]      val_q;
	logic [VALUE_BITS-1:0]      big_q;
	logic [AW-1:0]              pos_q;
	logic [AW-1:0]              bidx_q;
	logic [EW-1:0]              cidx_q;
	logic [CW-1:0]              cnt_q;
	logic [tkh_pkg::KEEP_W-1:0] keep_q;
	logic                       done_q;
	logic [VALUE_BITS-1:0]      popped_q;
	logic                       empty_q;
	logic [tkh_pkg::KEPT_W-1:0] kept_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [VALUE_BITS-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [VALUE_BITS-1:0] ram_rdata;

	logic [VALUE_BITS-1:0] cmp_a;
	logic [VALUE_BITS-1:0] cmp_b;
	logic                  gt;

	logic            accept;
	logic            full;
	logic            over;
	logic [EW-1:0]   cnt_ext;
	logic [EW-1:0]   child_w;
	logic [EW-1:0]   sib_w;
	logic            child_in;
	logic            sib_in;
	logic [AW-1:0]   parent;
	logic [CW-1:0]   cnt_m1;
	logic [AW-1:0]   last_addr;
	logic [LIMW-1:0] keep_ext;
	logic [LIMW-1:0] cap_ext;
	logic [LIMW-1:0] limit;
	logic [KXW-1:0]  kept_ext;

	// Heap store
	tkh_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Derive indexes and limits
	assign accept    = start && (state_q == tkh_pkg::S_IDLE);
	assign full      = (cnt_q == CW'(CAPACITY));
	assign cnt_ext   = EW'(cnt_q);
	assign child_w   = EW'({pos_q, 1'b1});
	assign sib_w     = cidx_q + EW'(1);
	assign child_in  = (child_w < cnt_ext);
	assign sib_in    = (sib_w < cnt_ext);
	assign parent    = (pos_q - AW'(1)) >> 1;
	assign cnt_m1    = cnt_q - CW'(1);
	assign last_addr = cnt_m1[AW-1:0];
	assign keep_ext  = LIMW'(keep_q);
	assign cap_ext   = LIMW'(CAPACITY);
	assign limit     = (keep_ext > cap_ext) ? cap_ext : keep_ext;
	assign over      = (LIMW'(cnt_q) > limit);
	assign kept_ext  = KXW'(cnt_m1);

	// Shared comparator: operands follow the sequencer state
	always_comb begin
		case (state_q)
			tkh_pkg::S_R_CMP: begin
				cmp_a = val_q;
				cmp_b = ram_rdata;
			end
			tkh_pkg::S_F_CMP: begin
				cmp_a = ram_rdata;
				cmp_b = val_q;
			end
			tkh_pkg::S_SK_C: begin
				cmp_a = ram_rdata;
				cmp_b = big_q;
			end
			tkh_pkg::S_SK_D: begin
				cmp_a = big_q;
				cmp_b = val_q;
			end
			default: begin
				cmp_a = val_q;
				cmp_b = big_q;
			end
		endcase
	end
	assign gt = (cmp_a > cmp_b);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkh_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and store access
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			tkh_pkg::S_IDLE: begin
				if (accept) begin
					if (op == tkh_pkg::OP_POP) begin
						state_d = (cnt_q == '0) ? tkh_pkg::S_IDLE : tkh_pkg::S_P_RD;
					end else begin
						state_d = full ? tkh_pkg::S_F_RD : tkh_pkg::S_R_CHK;
					end
				end
			end
			tkh_pkg::S_R_CHK: begin
				if (pos_q == '0) begin
					ram_we  = 1'b1;
					state_d = tkh_pkg::S_EV_CHK;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = parent;
					state_d   = tkh_pkg::S_R_CMP;
				end
			end
			tkh_pkg::S_R_CMP: begin
				ram_we = 1'b1;
				if (gt) begin
					ram_wdata = ram_rdata;
					state_d   = tkh_pkg::S_R_CHK;
				end else begin
					state_d = tkh_pkg::S_EV_CHK;
				end
			end
			tkh_pkg::S_EV_CHK: begin
				if (over) begin
					ram_re    = 1'b1;
					ram_raddr = last_addr;
					state_d   = tkh_pkg::S_EV_LD;
				end else begin
					state_d = tkh_pkg::S_IDLE;
				end
			end
			tkh_pkg::S_F_RD: begin
				ram_re  = 1'b1;
				state_d = tkh_pkg::S_F_CMP;
			end
			tkh_pkg::S_F_CMP: begin
				state_d = gt ? tkh_pkg::S_SK_A : tkh_pkg::S_IDLE;
			end
			tkh_pkg::S_P_RD: begin
				ram_re  = 1'b1;
				state_d = tkh_pkg::S_P_OUT;
			end
			tkh_pkg::S_P_OUT: begin
				ram_re    = 1'b1;
				ram_raddr = last_addr;
				state_d   = tkh_pkg::S_EV_LD;
			end
			tkh_pkg::S_EV_LD: begin
				state_d = tkh_pkg::S_SK_A;
			end
			tkh_pkg::S_SK_A: begin
				if (child_in) begin
					ram_re    = 1'b1;
					ram_raddr = child_w[AW-1:0];
					state_d   = tkh_pkg::S_SK_B;
				end else begin
					ram_we  = 1'b1;
					state_d = tkh_pkg::S_IDLE;
				end
			end
			tkh_pkg::S_SK_B: begin
				ram_re    = sib_in;
				ram_raddr = sib_w[AW-1:0];
				state_d   = tkh_pkg::S_SK_C;
			end
			tkh_pkg::S_SK_C: begin
				state_d = tkh_pkg::S_SK_D;
			end
			tkh_pkg::S_SK_D: begin
				ram_we = 1'b1;
				if (gt) begin
					ram_wdata = big_q;
					state_d   = tkh_pkg::S_SK_A;
				end else begin
					state_d = tkh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tkh_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers: entry count, keep limit, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			keep_q <= tkh_pkg::KEEP_RESET;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				keep_q <= cfg_data;
			end
			case (state_q)
				tkh_pkg::S_IDLE: begin
					if (accept) begin
						if (op == tkh_pkg::OP_POP) begin
							done_q <= (cnt_q == '0);
						end else if (!full) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				tkh_pkg::S_EV_CHK: begin
					if (over) begin
						cnt_q <= cnt_m1;
					end
				end
				tkh_pkg::S_P_OUT: begin
					cnt_q  <= cnt_m1;
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers: moving value, hole position, larger child, result
	always_ff @(posedge clk) begin
		case (state_q)
			tkh_pkg::S_IDLE: begin
				if (accept) begin
					val_q    <= sample_value;
					pos_q    <= cnt_q[AW-1:0];
					popped_q <= '0;
					empty_q  <= 1'b1;
					kept_q   <= '0;
				end
			end
			tkh_pkg::S_R_CMP: begin
				if (gt) begin
					pos_q <= parent;
				end
			end
			tkh_pkg::S_F_CMP: begin
				pos_q <= '0;
			end
			tkh_pkg::S_P_OUT: begin
				popped_q <= ram_rdata;
				empty_q  <= 1'b0;
				kept_q   <= kept_ext[tkh_pkg::KEPT_W-1:0];
			end
			tkh_pkg::S_EV_LD: begin
				val_q <= ram_rdata;
				pos_q <= '0;
			end
			tkh_pkg::S_SK_A: begin
				cidx_q <= child_w;
			end
			tkh_pkg::S_SK_B: begin
				big_q  <= ram_rdata;
				bidx_q <= cidx_q[AW-1:0];
			end
			tkh_pkg::S_SK_C: begin
				if (sib_in && gt) begin
					big_q  <= ram_rdata;
					bidx_q <= sib_w[AW-1:0];
				end
			end
			tkh_pkg::S_SK_D: begin
				if (gt) begin
					pos_q <= bidx_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Drive ports
	assign busy         = (state_q != tkh_pkg::S_IDLE);
	assign cfg_ready    = (state_q == tkh_pkg::S_IDLE);
	assign done         = done_q;
	assign popped_value = popped_q;
	assign was_empty    = empty_q;
	assign kept_after   = kept_q;

	// Checks
	`TKH_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CW'(CAPACITY), "entry count above capacity")
	`TKH_ASSERT_IMP(a_done_src, clk, arst_n, done, $past(busy || start), "result without an item")
	`TKH_ASSERT(a_empty_pop, clk, arst_n,
		(accept && op == tkh_pkg::OP_POP && cnt_q == '0) |=> (done && was_empty && kept_after == '0),
		"empty pop not reported")
	`TKH_ASSERT_IMP(a_busy_start, clk, arst_n, $rose(busy), $past(start), "busy without an accepted item")

endmodule

// ===== design/tkh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tkh_ram #(
	parameter int WIDTH = tkh_pkg::DEF_VALUE_BITS,
	parameter int DEPTH = tkh_pkg::DEF_CAPACITY
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== verif/top_k_smallest_heap_checker.sv =====
// Checker for the top-k heap selector: tracks the kept values and checks each pop result.
module top_k_smallest_heap_checker #(
	parameter int CAPACITY   = tkh_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = tkh_pkg::DEF_VALUE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic                       op,
	input  logic [VALUE_BITS-1:0]      sample_value,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [tkh_pkg::KEEP_W-1:0] cfg_data,
	input  logic                       done,
	input  logic [VALUE_BITS-1:0]      popped_value,
	input  logic                       was_empty,
	input  logic [tkh_pkg::KEPT_W-1:0] kept_after,
	output int                         mismatches,
	output int                         results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [VALUE_BITS-1:0]      value;
		logic                       empty;
		logic [tkh_pkg::KEPT_W-1:0] kept;
	} pop_result_t;

	// Max-heap of the kept values, largest at index 0
	logic [VALUE_BITS-1:0]      kept_values [CAPACITY];
	int unsigned                kept_total;
	logic [tkh_pkg::KEEP_W-1:0] keep_limit;
	pop_result_t                pops_owed [$];

	function automatic void swap_kept(input int unsigned a, input int unsigned b);
		logic [VALUE_BITS-1:0] t;
		t = kept_values[a];
		kept_values[a] = kept_values[b];
		kept_values[b] = t;
	endfunction

	// Move an entry up while it is larger than its parent; ties stay put
	function automatic void raise_kept(input int unsigned pos);
		int unsigned parent;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			if (kept_values[pos] > kept_values[parent]) begin
				swap_kept(pos, parent);
				pos = parent;
			end else
				break;
		end
	endfunction

	// Move an entry down toward its larger child while that child is larger
	function automatic void sink_kept(input int unsigned pos);
		int unsigned child;
		while (pos * 2 + 1 < kept_total) begin
			child = pos * 2 + 1;
			if (child + 1 < kept_total && kept_values[child + 1] > kept_values[child])
				child++;
			if (kept_values[child] > kept_values[pos]) begin
				swap_kept(child, pos);
				pos = child;
			end else
				break;
		end
	endfunction

	// Drop the root: last entry moves up and sinks
	function automatic void evict_largest();
		kept_total--;
		kept_values[0] = kept_values[kept_total];
		sink_kept(0);
	endfunction

	function automatic void predict_push(input logic [VALUE_BITS-1:0] v);
		int unsigned limit;
		limit = (keep_limit > CAPACITY) ? CAPACITY : keep_limit;
		if (kept_total >= CAPACITY) begin
			// full store: replace the root only with a smaller value
			if (v < kept_values[0]) begin
				kept_values[0] = v;
				sink_kept(0);
			end
		end else begin
			kept_values[kept_total] = v;
			kept_total++;
			raise_kept(kept_total - 1);
			if (kept_total > limit)
				evict_largest();
		end
	endfunction

	function automatic void predict_pop();
		pop_result_t r;
		if (kept_total == 0) begin
			r.value = '0;
			r.empty = 1'b1;
			r.kept  = '0;
		end else begin
			r.value = kept_values[0];
			evict_largest();
			r.empty = 1'b0;
			r.kept  = kept_total[tkh_pkg::KEPT_W-1:0];
		end
		pops_owed.push_back(r);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pop_result_t want;
		if (!arst_n) begin
			kept_total = 0;
			keep_limit = tkh_pkg::KEEP_RESET;
			pops_owed.delete();
			mismatches = 0;
			results_owed <= 0;
		end else begin
			// check a reported pop against the oldest one owed
			if (done === 1'b1) begin
				if (pops_owed.size() == 0)
					report_mismatch($sformatf("pop result with none owed: value %0d empty %b kept %0d",
						popped_value, was_empty, kept_after));
				else begin
					want = pops_owed.pop_front();
					if (popped_value !== want.value)
						report_mismatch($sformatf("popped_value %0d, expected %0d",
							popped_value, want.value));
					if (was_empty !== want.empty)
						report_mismatch($sformatf("was_empty %b, expected %b",
							was_empty, want.empty));
					if (kept_after !== want.kept)
						report_mismatch($sformatf("kept_after %0d, expected %0d",
							kept_after, want.kept));
				end
			end
			// take a new limit
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
				keep_limit = cfg_data;
			// advance the heap on an accepted item
			if (start === 1'b1 && busy === 1'b0) begin
				if (op == tkh_pkg::OP_PUSH)
					predict_push(sample_value);
				else
					predict_pop();
			end
			results_owed <= pops_owed.size();
		end
	end

endmodule

// ===== verif/top_k_smallest_heap_test.sv =====
// Testbench top for the top-k heap selector: clock, reset, stimulus and verdict.
module top_k_smallest_heap_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VB            = tkh_pkg::DEF_VALUE_BITS;
	localparam int CAP           = tkh_pkg::DEF_CAPACITY;
	localparam int KW            = tkh_pkg::KEEP_W;
	localparam int KPW           = tkh_pkg::KEPT_W;
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT   = 2000000;

	logic           clk          = 1'b0;
	logic           arst_n       = 1'b0;
	logic           start        = 1'b0;
	logic           op           = tkh_pkg::OP_PUSH;
	logic [VB-1:0]  sample_value = '0;
	logic           cfg_valid    = 1'b0;
	logic [KW-1:0]  cfg_data     = '0;
	logic           busy;
	logic           cfg_ready;
	logic           done;
	logic [VB-1:0]  popped_value;
	logic           was_empty;
	logic [KPW-1:0] kept_after;

	int   mismatches;
	int   results_owed;
	int   cycle_count = 0;
	int   calm_left   = 0;
	logic start_on    = 1'b0;

	top_k_smallest_heap dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.sample_value (sample_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.popped_value (popped_value),
		.was_empty    (was_empty),
		.kept_after   (kept_after)
	);

	top_k_smallest_heap_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.sample_value (sample_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.popped_value (popped_value),
		.was_empty    (was_empty),
		.kept_after   (kept_after),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[top_k_smallest_heap] ERROR");
			$finish;
		end
	end

	// Mostly back-to-back, some short gaps, a few long ones, and calm stretches
	function automatic int pick_gap();
		int roll;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Extremes and a narrow range for ties, otherwise full width
	function automatic logic [VB-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return VB'($urandom_range(0, 15));
			default: return VB'($urandom);
		endcase
	endfunction

	// Present one item and hold it until the block takes it
	task automatic send_item(input logic kind, input logic [VB-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			if (start_on) begin
				start <= 1'b0;
				start_on = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		op           <= kind;
		sample_value <= v;
		start_on = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Wait for every owed pop result, then let the heap finish its work
	task automatic settle();
		while (results_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_keep(input logic [KW-1:0] keep);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= keep;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	// Pop one item at a time until the block reports empty
	task automatic drain_heap();
		int n;
		if (start_on) begin
			start <= 1'b0;
			start_on = 1'b0;
		end
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		for (n = 0; n < CAP + 8; n++) begin
			send_item(tkh_pkg::OP_POP, pick_value());
			start <= 1'b0;
			start_on = 1'b0;
			do @(posedge clk); while (done !== 1'b1);
			if (was_empty === 1'b1)
				break;
		end
	endtask

	task automatic run_phase(input logic [KW-1:0] keep, input int count, input int push_pct);
		int i;
		write_keep(keep);
		for (i = 0; i < count; i++)
			send_item(($urandom_range(0, 99) < push_pct) ? tkh_pkg::OP_PUSH : tkh_pkg::OP_POP,
				pick_value());
		drain_heap();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset limit: empty pop, extremes, ties, alternating bit patterns
		send_item(tkh_pkg::OP_POP, '1);
		send_item(tkh_pkg::OP_PUSH, '0);
		send_item(tkh_pkg::OP_PUSH, '1);
		send_item(tkh_pkg::OP_PUSH, '1);
		send_item(tkh_pkg::OP_PUSH, VB'(5));
		send_item(tkh_pkg::OP_PUSH, VB'(5));
		send_item(tkh_pkg::OP_PUSH, {VB/2{2'b10}});
		send_item(tkh_pkg::OP_PUSH, {VB/2{2'b01}});
		drain_heap();

		// zero limit: every push is evicted at once
		write_keep('0);
		send_item(tkh_pkg::OP_PUSH, VB'(7));
		send_item(tkh_pkg::OP_PUSH, VB'(3));
		drain_heap();

		// one entry kept
		write_keep(KW'(1));
		send_item(tkh_pkg::OP_PUSH, VB'(9));
		send_item(tkh_pkg::OP_PUSH, VB'(4));
		send_item(tkh_pkg::OP_PUSH, VB'(12));
		drain_heap();

		run_phase(KW'(3), 80, 60);
		run_phase(KW'(2), 80, 55);
		repeat (5)
			run_phase(KW'($urandom_range(1, 40)), 40, 65);
		run_phase(KW'($urandom_range(41, 1023)), 80, 80);

		// limit above capacity saturates; fill the store, push past full, then mix
		write_keep('1);
		repeat (CAP + 24)
			send_item(tkh_pkg::OP_PUSH, pick_value());
		repeat (60)
			send_item(($urandom_range(0, 99) < 50) ? tkh_pkg::OP_PUSH : tkh_pkg::OP_POP,
				pick_value());
		start <= 1'b0;
		start_on = 1'b0;

		settle();
		if (mismatches == 0)
			$display("[top_k_smallest_heap] OK");
		else
			$display("[top_k_smallest_heap] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/tkh_pkg.sv
design/tkh_ram.sv
design/top_k_smallest_heap.sv
verif/top_k_smallest_heap_checker.sv
verif/top_k_smallest_heap_test.sv
